@@ hdl/lspx_pkg.sv @@
// ----------------------------------------------------------------------------
// lspx_pkg
// Shared widths, register indexes, CORDIC arctangent table and beat types
// for the lidar polar-to-Cartesian converter.
// ----------------------------------------------------------------------------
package lspx_pkg;

  // field widths
  localparam int DIST_W    = 24;
  localparam int POS_W     = 25;
  localparam int INTEN_W   = 16;
  localparam int ANGLE_W   = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  // datapath width: prescaled distance keeps 16 fraction bits (< 2^40) plus sign and growth
  localparam int ACC_W     = 42;
  localparam int RND_W     = 27;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_START = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP  = 2'd3;

  // 30 m in distance units
  localparam logic [DIST_W-1:0] RANGE_MAX_RST = 24'd122880;

  // 1/K of the CORDIC in Q30
  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

  localparam logic signed [RND_W-1:0] POS_LIMIT = 27'sd16777215;

  // atan(2^-i) in binary angle units
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  // side info that rides along with a beat
  typedef struct packed {
    logic               kept;
    logic               neg;
    logic [INTEN_W-1:0] intensity;
    logic               last;
  } lspx_meta_t;

  // one beat inside the rotation chain
  typedef struct packed {
    logic signed [ACC_W-1:0]   x;
    logic signed [ACC_W-1:0]   y;
    logic signed [ANGLE_W-1:0] z;
    lspx_meta_t                meta;
  } lspx_beam_t;

endpackage

@@ hdl/lspx_front.sv @@
// ----------------------------------------------------------------------------
// lspx_front
// Configuration registers, beam angle accumulator, range check, quadrant
// fold and distance prescale by 1/K. One register stage.
// ----------------------------------------------------------------------------
module lspx_front import lspx_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic [DIST_W-1:0]    distance,
  input  logic [INTEN_W-1:0]   intensity_in,
  input  logic                 not_a_number,
  input  logic                 first_of_scan,
  input  logic                 last_of_scan_in,
  output logic                 beam_valid,
  output lspx_beam_t           beam
);

  logic [DIST_W-1:0]  dist_lo;
  logic [DIST_W-1:0]  dist_hi;
  logic [ANGLE_W-1:0] angle_start;
  logic [ANGLE_W-1:0] angle_step;
  logic [ANGLE_W-1:0] beam_angle;

  logic [ANGLE_W-1:0] angle;
  logic               fold;
  logic [53:0]        prod;
  lspx_beam_t         beam_next;

  // angle of this beat and quadrant fold
  assign angle = first_of_scan ? angle_start : beam_angle;
  assign fold  = angle[ANGLE_W-1] ^ angle[ANGLE_W-2];
  assign prod  = {30'd0, distance} * {24'd0, INV_GAIN_Q30};

  always_comb begin
    beam_next.x              = $signed({2'b00, prod[53:14]});
    beam_next.y              = '0;
    beam_next.z              = $signed({angle[ANGLE_W-1] ^ fold, angle[ANGLE_W-2:0]});
    beam_next.meta.kept      = !not_a_number && (distance >= dist_lo) &&
                               (distance <= dist_hi);
    beam_next.meta.neg       = fold;
    beam_next.meta.intensity = intensity_in;
    beam_next.meta.last      = last_of_scan_in;
  end

  // control: registers, accumulator, valid
  always_ff @(posedge clk) begin
    if (rst) begin
      dist_lo     <= '0;
      dist_hi     <= RANGE_MAX_RST;
      angle_start <= '0;
      angle_step  <= '0;
      beam_angle  <= '0;
      beam_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_RANGE_MIN:   dist_lo     <= cfg_data[DIST_W-1:0];
          REG_RANGE_MAX:   dist_hi     <= cfg_data[DIST_W-1:0];
          REG_ANGLE_START: angle_start <= cfg_data[ANGLE_W-1:0];
          REG_ANGLE_STEP:  angle_step  <= cfg_data[ANGLE_W-1:0];
          default: ;
        endcase
      end
      if (en) begin
        beam_valid <= in_valid;
        if (in_valid) begin
          beam_angle <= angle + angle_step;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      beam <= beam_next;
    end
  end

endmodule

@@ hdl/lspx_cell.sv @@
// ----------------------------------------------------------------------------
// lspx_cell
// One CORDIC rotation cell: a fixed shift by STAGE and one table angle.
// Passes its registered beat to the next cell each enabled cycle.
// ----------------------------------------------------------------------------
module lspx_cell import lspx_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       beam_valid_i,
  input  lspx_beam_t beam_i,
  output logic       beam_valid_o,
  output lspx_beam_t beam_o
);

  logic signed [ACC_W-1:0]   xs;
  logic signed [ACC_W-1:0]   ys;
  logic signed [ANGLE_W-1:0] step_angle;
  lspx_beam_t                beam_next;

  assign xs         = beam_i.x >>> STAGE;
  assign ys         = beam_i.y >>> STAGE;
  assign step_angle = $signed(ATAN_TAB[STAGE]);

  // rotate toward zero residual angle
  always_comb begin
    beam_next = beam_i;
    if (!beam_i.z[ANGLE_W-1]) begin
      beam_next.x = beam_i.x - ys;
      beam_next.y = beam_i.y + xs;
      beam_next.z = beam_i.z - step_angle;
    end else begin
      beam_next.x = beam_i.x + ys;
      beam_next.y = beam_i.y - xs;
      beam_next.z = beam_i.z + step_angle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beam_valid_o <= 1'b0;
    end else if (en) begin
      beam_valid_o <= beam_valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      beam_o <= beam_next;
    end
  end

endmodule

@@ hdl/lspx_back.sv @@
// ----------------------------------------------------------------------------
// lspx_back
// Rounds the rotated vector to distance units, undoes the fold, saturates,
// and holds the result beat in the output register.
// ----------------------------------------------------------------------------
module lspx_back import lspx_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    beam_valid,
  input  lspx_beam_t              beam,
  output logic                    out_valid,
  output logic signed [POS_W-1:0] pos_x,
  output logic signed [POS_W-1:0] pos_y,
  output logic [INTEN_W-1:0]      intensity_out,
  output logic                    kept,
  output logic                    last_of_scan_out
);

  function automatic logic signed [POS_W-1:0] finish(
    input logic signed [ACC_W-1:0] v,
    input logic                    neg
  );
    logic signed [ACC_W-1:0] vr;
    logic signed [RND_W-1:0] r;
    begin
      vr = v + 42'sd32768;
      r  = RND_W'(vr >>> 16);
      if (neg) begin
        r = -r;
      end
      if (r > POS_LIMIT) begin
        r = POS_LIMIT;
      end else if (r < -POS_LIMIT) begin
        r = -POS_LIMIT;
      end
      finish = r[POS_W-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= beam_valid;
    end
  end

  // result payload; dropped beams report the origin
  always_ff @(posedge clk) begin
    if (en) begin
      pos_x            <= beam.meta.kept ? finish(beam.x, beam.meta.neg) : '0;
      pos_y            <= beam.meta.kept ? finish(beam.y, beam.meta.neg) : '0;
      intensity_out    <= beam.meta.intensity;
      kept             <= beam.meta.kept;
      last_of_scan_out <= beam.meta.last;
    end
  end

endmodule

@@ hdl/lidar_scan_polar_to_xy_unit.sv @@
// Path from input beat to result beat: front stage, the rotation cells in
// order, output stage.
// Throughput: one beat per cycle; the whole chain advances together and
// holds only while a finished result is stalled at the output.
// Reset (rst, synchronous): registers to defaults, beam angle 0, pipeline empty.
// ----------------------------------------------------------------------------
// lidar_scan_polar_to_xy_unit
// Lidar beam polar-to-Cartesian converter built as a chain of CORDIC cells.
// ----------------------------------------------------------------------------
module lidar_scan_polar_to_xy_unit import lspx_pkg::*; #(
  parameter int ROTATION_STAGES = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [DIST_W-1:0]       distance,
  input  logic [INTEN_W-1:0]      intensity_in,
  input  logic                    not_a_number,
  input  logic                    first_of_scan,
  input  logic                    last_of_scan_in,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [POS_W-1:0] pos_x,
  output logic signed [POS_W-1:0] pos_y,
  output logic [INTEN_W-1:0]      intensity_out,
  output logic                    kept,
  output logic                    last_of_scan_out
);

  logic       en;
  logic       chain_valid [ROTATION_STAGES+1];
  lspx_beam_t chain_beam  [ROTATION_STAGES+1];

  // chain moves unless the output holds a stalled beat
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  lspx_front u_front (
    .clk             (clk),
    .rst             (rst),
    .en              (en),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .distance        (distance),
    .intensity_in    (intensity_in),
    .not_a_number    (not_a_number),
    .first_of_scan   (first_of_scan),
    .last_of_scan_in (last_of_scan_in),
    .beam_valid      (chain_valid[0]),
    .beam            (chain_beam[0])
  );

  // rotation cells
  for (genvar i = 0; i < ROTATION_STAGES; i++) begin : g_cell
    lspx_cell #(.STAGE(i)) u_cell (
      .clk          (clk),
      .rst          (rst),
      .en           (en),
      .beam_valid_i (chain_valid[i]),
      .beam_i       (chain_beam[i]),
      .beam_valid_o (chain_valid[i+1]),
      .beam_o       (chain_beam[i+1])
    );
  end

  lspx_back u_back (
    .clk              (clk),
    .rst              (rst),
    .en               (en),
    .beam_valid       (chain_valid[ROTATION_STAGES]),
    .beam             (chain_beam[ROTATION_STAGES]),
    .out_valid        (out_valid),
    .pos_x            (pos_x),
    .pos_y            (pos_y),
    .intensity_out    (intensity_out),
    .kept             (kept),
    .last_of_scan_out (last_of_scan_out)
  );

endmodule

@@ hdl/lspx_checker.sv @@
// ----------------------------------------------------------------------------
// lspx_checker
// Port-level checks for the lidar converter, bound to the top level.
// ----------------------------------------------------------------------------
module lspx_checker import lspx_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [POS_W-1:0] pos_x,
  input logic signed [POS_W-1:0] pos_y,
  input logic [INTEN_W-1:0]      intensity_out,
  input logic                    kept,
  input logic                    last_of_scan_out
);

  // stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // stalled result beat keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(pos_x) && $stable(pos_y) && $stable(kept) &&
      $stable(intensity_out) && $stable(last_of_scan_out))
    else $error("result payload changed while stalled");

  // input is held back only by a stalled output
  a_in_stall: assert property (@(posedge clk)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // pipeline empties on reset
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat present after reset");

  // dropped beams report the origin
  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !kept |-> pos_x == '0 && pos_y == '0)
    else $error("dropped beam with nonzero position");

endmodule

bind lidar_scan_polar_to_xy_unit lspx_checker u_lspx_checker (.*);
